FILE: hw/rtl/tga_rle_pkg.sv
package tga_rle_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RLE_ENABLE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL = 2'd2;

    // depth_mode codes; the unused code decodes as BGRA
    localparam logic [1:0] MODE_INDEXED = 2'd0;
    localparam logic [1:0] MODE_BGR     = 2'd1;
    localparam logic [1:0] MODE_BGRA    = 2'd2;

    // tuser command codes
    localparam logic CMD_PALETTE = 1'b0;
    localparam logic CMD_PIXEL   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic       indexed;
        logic [7:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
    } t_pix;

endpackage

FILE: hw/rtl/tga_rle_palette.sv
module tga_rle_palette #(
    parameter int DEPTH = tga_rle_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [7:0]  i_wr_index,
    input  logic [23:0] i_wr_color,
    input  logic        i_rd_en,
    input  logic [7:0]  i_rd_index,
    output logic [23:0] o_rd_color
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(DEPTH);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rd_data;
    logic        r_rd_oor;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = ({1'b0, i_wr_index} < DEPTH_LIM);
    assign rd_in_range = ({1'b0, i_rd_index} < DEPTH_LIM);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in_range) begin
            r_mem[i_wr_index[AW-1:0]] <= i_wr_color;
        end
    end

    // read data holds while the requesting pixel waits downstream
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_index[AW-1:0]];
            r_rd_oor  <= !rd_in_range;
        end
    end

    assign o_rd_color = r_rd_oor ? 24'd0 : r_rd_data;

endmodule

FILE: hw/rtl/tga_rle_parser.sv
module tga_rle_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_accept,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_emit,
    output tga_rle_pkg::t_pix                   o_pix
);

    logic [1:0]  r_depth_mode;
    logic        r_rle_enable;
    logic [31:0] r_pixel_total;

    logic        r_await_header;
    logic [7:0]  r_packet_left;
    logic        r_packet_is_raw;
    logic [1:0]  r_byte_phase;
    logic [23:0] r_partial;
    logic [31:0] r_pixels_left;

    logic        n_await_header;
    logic [7:0]  n_packet_left;
    logic        n_packet_is_raw;
    logic [1:0]  n_byte_phase;
    logic [23:0] n_partial;
    logic [31:0] n_pixels_left;

    logic        active;
    logic        header_byte;
    logic [1:0]  last_phase;
    logic        pixel_done;
    logic        is_run;
    logic [7:0]  rep;
    logic        cfg_hit;

    assign active      = (r_pixels_left != 32'd0);
    assign header_byte = r_rle_enable && r_await_header;
    assign is_run      = r_rle_enable && !r_packet_is_raw;

    always_comb begin
        unique case (r_depth_mode)
            tga_rle_pkg::MODE_INDEXED: last_phase = 2'd0;
            tga_rle_pkg::MODE_BGR:     last_phase = 2'd2;
            default:                   last_phase = 2'd3;
        endcase
    end

    assign pixel_done = active && !header_byte && (r_byte_phase >= last_phase);
    assign o_emit     = pixel_done;

    // a run covers the whole packet, clipped to what the image has left
    always_comb begin
        if (is_run) begin
            rep = ({24'd0, r_packet_left} > r_pixels_left) ? r_pixels_left[7:0]
                                                           : r_packet_left;
        end else begin
            rep = 8'd1;
        end
    end

    always_comb begin
        n_await_header  = r_await_header;
        n_packet_left   = r_packet_left;
        n_packet_is_raw = r_packet_is_raw;
        n_byte_phase    = r_byte_phase;
        n_partial       = r_partial;
        n_pixels_left   = r_pixels_left;
        if (active) begin
            if (header_byte) begin
                n_packet_left   = {1'b0, i_data_byte[6:0]} + 8'd1;
                n_packet_is_raw = !i_data_byte[7];
                n_await_header  = 1'b0;
                n_byte_phase    = 2'd0;
                n_partial       = 24'd0;
            end else if (!pixel_done) begin
                case (r_byte_phase)
                    2'd0:    n_partial[7:0]   = i_data_byte;
                    2'd1:    n_partial[15:8]  = i_data_byte;
                    default: n_partial[23:16] = i_data_byte;
                endcase
                n_byte_phase = r_byte_phase + 2'd1;
            end else begin
                n_byte_phase  = 2'd0;
                n_partial     = 24'd0;
                n_pixels_left = r_pixels_left - {24'd0, rep};
                if (is_run) begin
                    n_packet_left  = 8'd0;
                    n_await_header = 1'b1;
                end else if (r_rle_enable) begin
                    n_packet_left = r_packet_left - 8'd1;
                    if (r_packet_left == 8'd1) begin
                        n_await_header = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_pix              = '0;
        o_pix.repeat_count = rep;
        o_pix.image_done   = (r_pixels_left == {24'd0, rep});
        o_pix.alpha        = tga_rle_pkg::ALPHA_OPAQUE;
        unique case (r_depth_mode)
            tga_rle_pkg::MODE_INDEXED: begin
                o_pix.indexed     = 1'b1;
                o_pix.color_index = i_data_byte;
            end
            tga_rle_pkg::MODE_BGR: begin
                o_pix.blue  = r_partial[7:0];
                o_pix.green = r_partial[15:8];
                o_pix.red   = i_data_byte;
            end
            default: begin
                o_pix.blue  = r_partial[7:0];
                o_pix.green = r_partial[15:8];
                o_pix.red   = r_partial[23:16];
                o_pix.alpha = i_data_byte;
            end
        endcase
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index == tga_rle_pkg::REG_DEPTH_MODE ||
                                  i_cfg_index == tga_rle_pkg::REG_RLE_ENABLE ||
                                  i_cfg_index == tga_rle_pkg::REG_PIXEL_TOTAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode    <= tga_rle_pkg::MODE_BGR;
            r_rle_enable    <= 1'b0;
            r_pixel_total   <= 32'd0;
            r_await_header  <= 1'b1;
            r_packet_left   <= 8'd0;
            r_packet_is_raw <= 1'b0;
            r_byte_phase    <= 2'd0;
            r_partial       <= 24'd0;
            r_pixels_left   <= 32'd0;
        end else if (cfg_hit) begin
            // any register write restarts the stream
            r_await_header  <= 1'b1;
            r_packet_left   <= 8'd0;
            r_packet_is_raw <= 1'b0;
            r_byte_phase    <= 2'd0;
            r_partial       <= 24'd0;
            r_pixels_left   <= r_pixel_total;
            unique case (i_cfg_index)
                tga_rle_pkg::REG_DEPTH_MODE:  r_depth_mode <= i_cfg_data[1:0];
                tga_rle_pkg::REG_RLE_ENABLE:  r_rle_enable <= i_cfg_data[0];
                default: begin
                    r_pixel_total <= i_cfg_data;
                    r_pixels_left <= i_cfg_data;
                end
            endcase
        end else if (i_accept) begin
            r_await_header  <= n_await_header;
            r_packet_left   <= n_packet_left;
            r_packet_is_raw <= n_packet_is_raw;
            r_byte_phase    <= n_byte_phase;
            r_partial       <= n_partial;
            r_pixels_left   <= n_pixels_left;
        end
    end

endmodule

FILE: hw/rtl/tga_rle_out.sv
module tga_rle_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  tga_rle_pkg::t_pix                   i_pix,
    input  logic [23:0]                         i_pal_color,
    input  logic                                i_m_tready,
    output logic                                o_ready,
    output logic                                o_m_tvalid,
    output logic [tga_rle_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                                o_m_tlast
);

    logic              r_s1_valid;
    tga_rle_pkg::t_pix r_s1;
    logic              r_o_valid;
    logic [tga_rle_pkg::OUT_TDATA_W-1:0] r_o_data;
    logic              r_o_last;

    logic        s1_adv;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    assign s1_adv  = r_s1_valid && (!r_o_valid || i_m_tready);
    assign o_ready = !r_s1_valid || s1_adv;

    // palette data arrives in the cycle after the pixel was parsed
    always_comb begin
        if (r_s1.indexed) begin
            red   = i_pal_color[23:16];
            green = i_pal_color[15:8];
            blue  = i_pal_color[7:0];
        end else begin
            red   = r_s1.red;
            green = r_s1.green;
            blue  = r_s1.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_load;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_s1 <= i_pix;
        end
        if (s1_adv) begin
            r_o_data <= {r_s1.repeat_count, r_s1.alpha, blue, green, red,
                         r_s1.color_index};
            r_o_last <= r_s1.image_done;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule

FILE: hw/rtl/tga_rle_pixel_decoder.sv
// TGA pixel-section decoder.
// Slave stream: one transaction per byte. tuser = cmd: CMD_PIXEL carries a
// pixel-data byte, CMD_PALETTE writes palette_color into palette_index.
// Master stream: one transaction per decoded pixel (or per run), RGBA plus
// palette index and repeat count; tlast marks the pixel that ends the image.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, write only. Every write
// to depth_mode, rle_enable or pixel_total restarts the stream and reloads
// the pixel counter; write only while the block is idle.
// Throughput: one byte per cycle while the master side keeps up. A byte
// that completes a pixel passes the stage register, beside the registered
// palette read, and then the output register on its way to the master side.
// Reset: parse state and both pipeline stages clear, depth_mode = 24-bit,
// rle off, pixel_total = 0 (pixel bytes are dropped until configured).
// Palette contents are not cleared.
// Stall: a held result sits in the output register, a second one in the
// stage behind it; with both full, s_axis_tready drops until the master
// side takes a transaction.
module tga_rle_pixel_decoder #(
    parameter int PALETTE_DEPTH = tga_rle_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_byte[7:0], palette_index[15:8], palette_color[39:16]
    input  logic [tga_rle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // color_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32],
    // repeat_count[47:40]
    output logic [tga_rle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                m_axis_tlast
);

    logic              accept;
    logic              pixel_accept;
    logic              pal_write;
    logic              emit;
    logic              load;
    tga_rle_pkg::t_pix pix;
    logic [23:0]       pal_color;

    assign accept       = s_axis_tvalid && s_axis_tready;
    assign pixel_accept = accept && (s_axis_tuser == tga_rle_pkg::CMD_PIXEL);
    assign pal_write    = accept && (s_axis_tuser == tga_rle_pkg::CMD_PALETTE);
    assign load         = pixel_accept && emit;

    tga_rle_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (pixel_accept),
        .i_data_byte (s_axis_tdata[7:0]),
        .o_emit      (emit),
        .o_pix       (pix)
    );

    tga_rle_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk      (i_clk),
        .i_wr_en    (pal_write),
        .i_wr_index (s_axis_tdata[15:8]),
        .i_wr_color (s_axis_tdata[39:16]),
        .i_rd_en    (load),
        .i_rd_index (s_axis_tdata[7:0]),
        .o_rd_color (pal_color)
    );

    tga_rle_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_pix       (pix),
        .i_pal_color (pal_color),
        .i_m_tready  (m_axis_tready),
        .o_ready     (s_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

FILE: hw/rtl/tga_rle_checker.sv
module tga_rle_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tga_rle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                                m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[47:40] != 8'd0) &&
                          (m_axis_tdata[47:40] <= 8'd128))
        else $error("repeat count out of range");

    // a nonzero palette index only comes from indexed mode, which is opaque
    a_index_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |->
            (m_axis_tdata[39:32] == tga_rle_pkg::ALPHA_OPAQUE))
        else $error("indexed pixel with non-opaque alpha");

    // an empty output fills from an accepted byte via the stage and output registers
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a source transaction");

endmodule

bind tga_rle_pixel_decoder tga_rle_checker u_tga_rle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: test/tga_rle_pixel_decoder_tb.sv
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_tb;

    localparam int ITEM_TARGET = 750;
    localparam int STALL_LIMIT = 2000;

    localparam logic [7:0] OPAQUE = tga_rle_pkg::ALPHA_OPAQUE;

    typedef struct packed {
        logic [7:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
    } t_exp_pix;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind                           kind;
        logic [tga_rle_pkg::CFG_INDEX_W-1:0] reg_sel;
        logic [tga_rle_pkg::CFG_DATA_W-1:0]  value;
        logic                                cmd;
        logic [7:0]                          data;
        logic [7:0]                          pidx;
        logic [23:0]                         pcol;
        bit                                  typed;
        t_exp_pix                            want;
    } t_row;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [tga_rle_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [tga_rle_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [tga_rle_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                                s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [tga_rle_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                                m_axis_tlast;

    tga_rle_pixel_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // decoder state as seen from outside
    logic [23:0] pal_mem [256];
    bit          pal_valid [256];
    logic [7:0]  pal_used [$];
    logic [1:0]  cur_mode = tga_rle_pkg::MODE_BGR;
    logic        cur_rle = 1'b0;
    logic [31:0] cur_total = '0;
    logic        want_header = 1'b1;
    logic [7:0]  run_left = '0;
    logic        run_is_raw = 1'b0;
    logic [1:0]  byte_pos = '0;
    logic [23:0] pixel_acc = '0;
    logic [31:0] pixels_left_q = '0;

    t_exp_pix pixels_due [$];
    int       fail_count = 0;
    int       fed_items = 0;
    int       hold_cycles = 0;
    bit       steady = 1'b0;
    int       idle_cycles = 0;
    t_row     plan [$];

    function automatic bit gap_roll();
        return !steady && ($urandom_range(99) < 19);
    endfunction

    function automatic bit decode_byte(input logic cmd, input logic [7:0] data,
                                       input logic [7:0] pidx,
                                       input logic [23:0] pcol,
                                       output t_exp_pix px);
        logic [23:0] c;
        logic [31:0] rep;
        int          bpp;
        px = '0;
        px.alpha = tga_rle_pkg::ALPHA_OPAQUE;
        if (cmd == tga_rle_pkg::CMD_PALETTE) begin
            pal_mem[pidx] = pcol;
            if (!pal_valid[pidx]) begin
                pal_valid[pidx] = 1'b1;
                pal_used.push_back(pidx);
            end
            return 1'b0;
        end
        if (pixels_left_q == 0) return 1'b0;
        if (cur_rle && want_header) begin
            run_left    = {1'b0, data[6:0]} + 8'd1;
            run_is_raw  = ~data[7];
            want_header = 1'b0;
            byte_pos    = '0;
            pixel_acc   = '0;
            return 1'b0;
        end
        bpp = (cur_mode == tga_rle_pkg::MODE_INDEXED) ? 1
            : (cur_mode == tga_rle_pkg::MODE_BGR) ? 3 : 4;
        if (byte_pos + 1 < bpp) begin
            pixel_acc = pixel_acc | (24'(data) << (8 * byte_pos));
            byte_pos  = byte_pos + 2'd1;
            return 1'b0;
        end
        case (cur_mode)
            tga_rle_pkg::MODE_INDEXED: begin
                c              = pal_mem[data];
                px.color_index = data;
                px.red         = c[23:16];
                px.green       = c[15:8];
                px.blue        = c[7:0];
            end
            tga_rle_pkg::MODE_BGR: begin
                px.blue  = pixel_acc[7:0];
                px.green = pixel_acc[15:8];
                px.red   = data;
            end
            default: begin
                px.blue  = pixel_acc[7:0];
                px.green = pixel_acc[15:8];
                px.red   = pixel_acc[23:16];
                px.alpha = data;
            end
        endcase
        byte_pos  = '0;
        pixel_acc = '0;
        if (cur_rle && !run_is_raw) begin
            // one result covers the whole run, clipped at the image end
            rep         = ({24'b0, run_left} > pixels_left_q) ? pixels_left_q
                                                              : {24'b0, run_left};
            run_left    = '0;
            want_header = 1'b1;
        end else begin
            rep = 1;
            if (cur_rle) begin
                run_left = run_left - 8'd1;
                if (run_left == 0) want_header = 1'b1;
            end
        end
        pixels_left_q   = pixels_left_q - rep;
        px.repeat_count = rep[7:0];
        px.image_done   = (pixels_left_q == 0);
        return 1'b1;
    endfunction

    function automatic t_row cfg_row(input logic [tga_rle_pkg::CFG_INDEX_W-1:0] r,
                                     input logic [tga_rle_pkg::CFG_DATA_W-1:0] v);
        t_row row;
        row = '{kind: ROW_CFG, reg_sel: r, value: v, default: '0};
        return row;
    endfunction

    function automatic t_row item_row(input logic cmd, input logic [7:0] data,
                                      input logic [7:0] pidx, input logic [23:0] pcol);
        t_row row;
        row = '{kind: ROW_ITEM, cmd: cmd, data: data, pidx: pidx, pcol: pcol,
                default: '0};
        return row;
    endfunction

    function automatic t_row pixel_row(input logic [7:0] data, input t_exp_pix want);
        t_row row;
        row = '{kind: ROW_ITEM, cmd: tga_rle_pkg::CMD_PIXEL, data: data, typed: 1'b1,
                want: want, default: '0};
        return row;
    endfunction

    task automatic send_item(input logic cmd, input logic [7:0] data,
                             input logic [7:0] pidx, input logic [23:0] pcol,
                             input bit typed = 1'b0, input t_exp_pix want = '0);
        t_exp_pix px;
        bit       got;
        // never look up a palette entry that was not loaded
        if (cmd == tga_rle_pkg::CMD_PIXEL && pixels_left_q != 0
                && !(cur_rle && want_header)
                && cur_mode == tga_rle_pkg::MODE_INDEXED && !pal_valid[data])
            data = pal_used[$urandom_range(pal_used.size() - 1)];
        if (cmd == tga_rle_pkg::CMD_PALETTE || pixels_left_q != 0) fed_items++;
        got = decode_byte(cmd, data, pidx, pcol, px);
        if (typed) pixels_due.push_back(want);
        else if (got) pixels_due.push_back(px);

        @(negedge i_clk);
        while (gap_roll()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pcol, pidx, data};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_noise_byte();
        send_item(tga_rle_pkg::CMD_PIXEL, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 24'($urandom));
    endtask

    task automatic drain_outputs();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        // header or partial bytes may still be in flight with nothing queued
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tga_rle_pkg::CFG_INDEX_W-1:0] r,
                             input logic [tga_rle_pkg::CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (r)
            tga_rle_pkg::REG_DEPTH_MODE:  cur_mode  = v[1:0];
            tga_rle_pkg::REG_RLE_ENABLE:  cur_rle   = v[0];
            tga_rle_pkg::REG_PIXEL_TOTAL: cur_total = v;
            default: return;
        endcase
        want_header   = 1'b1;
        run_left      = '0;
        run_is_raw    = 1'b0;
        byte_pos      = '0;
        pixel_acc     = '0;
        pixels_left_q = cur_total;
    endtask

    task automatic run_phase(input int p);
        logic [1:0]  mode;
        logic        rle;
        logic [31:0] total;
        logic [6:0]  count;
        logic        is_run;
        int          quota, start, nbytes, roll, bpp;
        bit          stalled, paused;
        stalled = 1'b0;
        paused  = 1'b0;
        mode = (p < 8) ? 2'(p % 4) : 2'($urandom_range(3));
        rle  = (p < 8) ? (p >= 4) : 1'($urandom_range(1));
        case (p)
            1, 5:    total = 32'hFFFE_0001;
            2:       total = '0;
            6:       total = $urandom;
            default: total = ($urandom_range(9) < 7) ? $urandom_range(1, 48)
                                                     : $urandom_range(49, 300);
        endcase
        drain_outputs();
        steady = (p % 5 == 3);
        write_reg(tga_rle_pkg::REG_DEPTH_MODE, 32'(mode));
        write_reg(tga_rle_pkg::REG_RLE_ENABLE, 32'(rle));
        write_reg(tga_rle_pkg::REG_PIXEL_TOTAL, total);
        bpp   = (mode == tga_rle_pkg::MODE_INDEXED) ? 1
              : (mode == tga_rle_pkg::MODE_BGR) ? 3 : 4;
        quota = $urandom_range(40, 110);
        start = fed_items;
        while (fed_items - start < quota && pixels_left_q != 0) begin
            if (p == 1 && !stalled && fed_items - start >= 30) begin
                stalled     = 1'b1;
                hold_cycles = 80;
            end
            if (p == 5 && !paused && fed_items - start >= 30) begin
                paused = 1'b1;
                drain_outputs();
            end
            roll = $urandom_range(99);
            if (roll < 6) begin
                send_item(tga_rle_pkg::CMD_PALETTE, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 24'($urandom));
            end else if (roll < 12) begin
                send_noise_byte();
            end else begin
                nbytes = bpp;
                if (rle) begin
                    count  = ($urandom_range(19) == 0) ? 7'd127
                           : ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                           : 7'($urandom_range(5));
                    is_run = 1'($urandom_range(1));
                    send_item(tga_rle_pkg::CMD_PIXEL, {is_run, count},
                              8'($urandom_range(255)), 24'($urandom));
                    if (!is_run) nbytes = (count + 1) * bpp;
                end
                // now and then cut the packet short
                if ($urandom_range(19) == 0) nbytes = $urandom_range(nbytes - 1);
                for (int k = 0; k < nbytes && pixels_left_q != 0; k++)
                    send_noise_byte();
            end
        end
        repeat ($urandom_range(1, 3)) send_noise_byte();
        steady = 1'b0;
    endtask

    // result side: random backpressure plus an occasional long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !gap_roll();
            end
        end
    end

    always @(posedge i_clk) begin
        t_exp_pix got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[31:24], m_axis_tdata[39:32], m_axis_tdata[47:40],
                   m_axis_tlast};
            if (pixels_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected pixel: idx=%h rgba=%h_%h_%h_%h rep=%0d last=%b",
                             $realtime, got.color_index, got.red, got.green, got.blue,
                             got.alpha, got.repeat_count, got.image_done);
            end else begin
                want = pixels_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: pixel mismatch: exp idx=%h rgba=%h_%h_%h_%h rep=%0d last=%b",
                                 $realtime, want.color_index, want.red, want.green,
                                 want.blue, want.alpha, want.repeat_count, want.image_done);
                        $display("%0t:                 got idx=%h rgba=%h_%h_%h_%h rep=%0d last=%b",
                                 $realtime, got.color_index, got.red, got.green,
                                 got.blue, got.alpha, got.repeat_count, got.image_done);
                    end
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 256; i++) begin
            pal_mem[i]   = '0;
            pal_valid[i] = 1'b0;
        end
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tga_rle_pkg::CMD_PALETTE;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no image configured after reset: the byte is dropped
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'hFF, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PALETTE, 8'h00, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PALETTE, 8'hFF, 8'hFF, 24'hFFFFFF));
        plan.push_back(item_row(tga_rle_pkg::CMD_PALETTE, 8'h5A, 8'hA5, 24'h123456));
        plan.push_back(cfg_row(tga_rle_pkg::REG_DEPTH_MODE, 32'(tga_rle_pkg::MODE_INDEXED)));
        plan.push_back(cfg_row(tga_rle_pkg::REG_RLE_ENABLE, 32'd0));
        plan.push_back(cfg_row(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd3));
        plan.push_back(pixel_row(8'h00,
                                 '{8'h00, 8'h00, 8'h00, 8'h00, OPAQUE, 8'd1, 1'b0}));
        plan.push_back(pixel_row(8'hFF,
                                 '{8'hFF, 8'hFF, 8'hFF, 8'hFF, OPAQUE, 8'd1, 1'b0}));
        plan.push_back(pixel_row(8'hA5,
                                 '{8'hA5, 8'h12, 8'h34, 8'h56, OPAQUE, 8'd1, 1'b1}));
        // past the image end
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h00, 8'h00, 24'h000000));
        plan.push_back(cfg_row(tga_rle_pkg::REG_DEPTH_MODE, 32'(tga_rle_pkg::MODE_BGR)));
        plan.push_back(cfg_row(tga_rle_pkg::REG_RLE_ENABLE, 32'd1));
        plan.push_back(cfg_row(tga_rle_pkg::REG_PIXEL_TOTAL, 32'd4));
        // run of two
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h81, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h01, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h02, 8'h00, 24'h000000));
        plan.push_back(pixel_row(8'h03,
                                 '{8'h00, 8'h03, 8'h02, 8'h01, OPAQUE, 8'd2, 1'b0}));
        // raw, one pixel
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h00, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'hFF, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'hFF, 8'h00, 24'h000000));
        plan.push_back(pixel_row(8'hFF,
                                 '{8'h00, 8'hFF, 8'hFF, 8'hFF, OPAQUE, 8'd1, 1'b0}));
        // run of 128 with one pixel left
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'hFF, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h10, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h20, 8'h00, 24'h000000));
        plan.push_back(pixel_row(8'h30,
                                 '{8'h00, 8'h30, 8'h20, 8'h10, OPAQUE, 8'd1, 1'b1}));
        plan.push_back(cfg_row(tga_rle_pkg::REG_DEPTH_MODE, 32'(tga_rle_pkg::MODE_BGRA)));
        plan.push_back(cfg_row(tga_rle_pkg::REG_RLE_ENABLE, 32'd0));
        plan.push_back(cfg_row(tga_rle_pkg::REG_PIXEL_TOTAL, 32'hFFFE_0001));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h11, 8'h00, 24'h000000));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h22, 8'h00, 24'h000000));
        // palette load in mid-pixel leaves the parse alone
        plan.push_back(item_row(tga_rle_pkg::CMD_PALETTE, 8'h00, 8'h01, 24'hABCDEF));
        plan.push_back(item_row(tga_rle_pkg::CMD_PIXEL, 8'h33, 8'h00, 24'h000000));
        plan.push_back(pixel_row(8'h44,
                                 '{8'h00, 8'h33, 8'h22, 8'h11, 8'h44, 8'd1, 1'b0}));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain_outputs();
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                send_item(plan[i].cmd, plan[i].data, plan[i].pidx, plan[i].pcol,
                          plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; fed_items < ITEM_TARGET; p++)
            run_phase(p);

        drain_outputs();
        repeat (8) @(posedge i_clk);
        fail_count += pixels_due.size();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
